// ===== rtl/nfbia_pkg.sv =====
// ----------------------------------------------------------------------------
// nfbia_pkg: next-fit bitmap id allocator shared definitions
// Default sizes, status codes, register indexes and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package nfbia_pkg;

   localparam int DEFAULT_MAX_IDS   = 1024;
   localparam int DEFAULT_WORD_BITS = 64;
   localparam int DEFAULT_USABLE    = 1000;

   // register index on the csr port
   localparam int CSR_USABLE_COUNT = 0;

   // request kinds
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_NOT_USED = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       clear;       // write one zero word of the clearing pass
      logic       load;        // capture the request fields
      logic       scan_init;   // set up the next-fit word scan
      logic       scan;        // advance the word scan
      logic       commit;      // write back the granted bit and answer
      logic       rel_commit;  // check and clear the released bit and answer
      logic       resp_err;    // answer with resp_code and no state change
      status_type resp_code;
   } nfbia_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic op_release;
      logic limit_zero;
      logic rid_oob;
      logic scan_hit;
      logic scan_full;
   } nfbia_stat_type;

endpackage

// ===== rtl/nfbia_ram.sv =====
// ----------------------------------------------------------------------------
// nfbia_ram: generic single write port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nfbia_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nfbia_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfbia_ctrl: allocator controller
// Sequences the clearing pass, request decode, word scan and write back.
// ----------------------------------------------------------------------------
module nfbia_ctrl
   import nfbia_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  nfbia_stat_type stat,
   output nfbia_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR     = 6'b000001,
      ST_IDLE      = 6'b000010,
      ST_DECODE    = 6'b000100,
      ST_SCAN      = 6'b001000,
      ST_COMMIT    = 6'b010000,
      ST_REL_CHECK = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.resp_code = STATUS_OK;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.op_release) begin
               if (stat.rid_oob) begin
                  cmd.resp_err  = 1'b1;
                  cmd.resp_code = STATUS_RANGE;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_REL_CHECK;
               end
            end else if (stat.limit_zero) begin
               cmd.resp_err  = 1'b1;
               cmd.resp_code = STATUS_FULL;
               state_in      = ST_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_hit) begin
               state_in = ST_COMMIT;
            end else if (stat.scan_full) begin
               cmd.resp_err  = 1'b1;
               cmd.resp_code = STATUS_FULL;
               state_in      = ST_IDLE;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_REL_CHECK: begin
            cmd.rel_commit = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/nfbia_datapath.sv =====
// ----------------------------------------------------------------------------
// nfbia_datapath: allocator datapath
// Holds the counters, the pipelined word scan, the bit update and the
// result registers; the bitmap itself lives in an external ram.
// ----------------------------------------------------------------------------
module nfbia_datapath
   import nfbia_pkg::*;
#(
   parameter int MAX_IDS   = DEFAULT_MAX_IDS,
   parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  nfbia_cmd_type             cmd,
   output nfbia_stat_type            stat,
   input  logic                      req_op,
   input  logic [$clog2(MAX_IDS)-1:0] req_release_id,
   input  logic [$clog2(MAX_IDS):0]   usable_count,
   output logic                      ram_wr_en,
   output logic [((MAX_IDS / WORD_BITS > 1) ? $clog2(MAX_IDS / WORD_BITS) : 1)-1:0]
                                     ram_wr_addr,
   output logic [WORD_BITS-1:0]      ram_wr_data,
   output logic [((MAX_IDS / WORD_BITS > 1) ? $clog2(MAX_IDS / WORD_BITS) : 1)-1:0]
                                     ram_rd_addr,
   input  logic [WORD_BITS-1:0]      ram_rd_data,
   output logic                      rsp_strobe,
   output logic [1:0]                rsp_status,
   output logic [$clog2(MAX_IDS)-1:0] rsp_granted_id,
   output logic [$clog2(MAX_IDS):0]   rsp_in_use
);

   localparam int MAP_WORDS = MAX_IDS / WORD_BITS;
   localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int ID_W      = $clog2(MAX_IDS);
   localparam int CNT_W     = ID_W + 1;

   function automatic logic [BIT_W-1:0] first_one(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

   // request
   logic             op_ff, op_in;
   logic [ID_W-1:0]  rid_ff, rid_in;

   // allocator state
   logic [CNT_W-1:0] used_total_ff, used_total_in;
   logic [CNT_W-1:0] search_start_ff, search_start_in;
   logic [WADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // scan pipeline
   logic [WADDR_W-1:0] iss_addr_ff, iss_addr_in;
   logic               iss_active_ff, iss_active_in;
   logic               iss_first_ff, iss_first_in;
   logic               pass2_ff, pass2_in;
   logic [WADDR_W-1:0] end_addr_ff, end_addr_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [WADDR_W-1:0] chk_addr_ff, chk_addr_in;
   logic               chk_first_ff, chk_first_in;
   logic               chk_last_ff, chk_last_in;

   // granted bit, held for write back
   logic [WADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [WORD_BITS-1:0] wr_word_ff, wr_word_in;
   logic [ID_W-1:0]      found_id_ff, found_id_in;

   // result
   logic             rsp_strobe_ff, rsp_strobe_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [CNT_W-1:0] rsp_in_use_ff, rsp_in_use_in;

   // derived values
   logic [CNT_W-1:0]     limit;
   logic [ID_W-1:0]      last_id;
   logic [WADDR_W-1:0]   last_word;
   logic [BIT_W-1:0]     last_bit;
   logic                 start_oob;
   logic [WADDR_W-1:0]   start_word;
   logic [BIT_W-1:0]     start_bit;
   logic [WADDR_W-1:0]   rid_word;
   logic [BIT_W-1:0]     rid_bit;
   logic [WORD_BITS-1:0] rid_mask;
   logic [WORD_BITS-1:0] hi_mask;
   logic [WORD_BITS-1:0] lo_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic [BIT_W-1:0]     free_idx;
   logic                 any_free;
   logic                 hit;
   logic                 miss_last;

   always_comb begin
      limit = (usable_count > CNT_W'(MAX_IDS)) ? CNT_W'(MAX_IDS) : usable_count;
      last_id    = ID_W'(limit - CNT_W'(1));
      last_word  = WADDR_W'(last_id >> BIT_W);
      last_bit   = last_id[BIT_W-1:0];
      start_oob  = (search_start_ff >= limit);
      start_word = WADDR_W'(search_start_ff[ID_W-1:0] >> BIT_W);
      start_bit  = search_start_ff[BIT_W-1:0];
      rid_word   = WADDR_W'(rid_ff >> BIT_W);
      rid_bit    = rid_ff[BIT_W-1:0];
      rid_mask   = WORD_BITS'(1) << rid_bit;

      // bits past the usable range and below the pointer count as used
      hi_mask   = (chk_addr_ff == last_word) ?
                  ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_bit)) :
                  {WORD_BITS{1'b1}};
      lo_mask   = chk_first_ff ? ({WORD_BITS{1'b1}} << start_bit) : {WORD_BITS{1'b1}};
      free_bits = ~ram_rd_data & hi_mask & lo_mask;
      any_free  = |free_bits;
      free_idx  = first_one(free_bits);
      hit       = cmd.scan && chk_valid_ff && any_free;
      miss_last = cmd.scan && chk_valid_ff && !any_free && chk_last_ff;
   end

   always_comb begin
      stat.clear_done = (clr_addr_ff == WADDR_W'(MAP_WORDS - 1));
      stat.op_release = (op_ff == OP_RELEASE);
      stat.limit_zero = (limit == '0);
      stat.rid_oob    = ({1'b0, rid_ff} >= limit);
      stat.scan_hit   = hit;
      stat.scan_full  = miss_last && pass2_ff;
   end

   always_comb begin
      op_in           = op_ff;
      rid_in          = rid_ff;
      used_total_in   = used_total_ff;
      search_start_in = search_start_ff;
      clr_addr_in     = clr_addr_ff;
      iss_addr_in     = iss_addr_ff;
      iss_active_in   = iss_active_ff;
      iss_first_in    = iss_first_ff;
      pass2_in        = pass2_ff;
      end_addr_in     = end_addr_ff;
      chk_valid_in    = chk_valid_ff;
      chk_addr_in     = chk_addr_ff;
      chk_first_in    = chk_first_ff;
      chk_last_in     = chk_last_ff;
      wr_addr_in      = wr_addr_ff;
      wr_word_in      = wr_word_ff;
      found_id_in     = found_id_ff;
      rsp_strobe_in   = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_in_use_in   = rsp_in_use_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = clr_addr_ff;
      ram_wr_data     = '0;
      ram_rd_addr     = cmd.scan ? iss_addr_ff : rid_word;

      if (cmd.clear) begin
         ram_wr_en   = 1'b1;
         clr_addr_in = clr_addr_ff + WADDR_W'(1);
      end

      if (cmd.load) begin
         op_in  = req_op;
         rid_in = req_release_id;
      end

      if (cmd.scan_init) begin
         iss_active_in = 1'b1;
         end_addr_in   = last_word;
         chk_valid_in  = 1'b0;
         if (start_oob) begin
            pass2_in     = 1'b1;
            iss_addr_in  = '0;
            iss_first_in = 1'b0;
         end else begin
            pass2_in     = 1'b0;
            iss_addr_in  = start_word;
            iss_first_in = 1'b1;
         end
      end

      if (cmd.scan) begin
         // issue the next word read while the previous word is checked
         chk_valid_in = iss_active_ff;
         chk_addr_in  = iss_addr_ff;
         chk_first_in = iss_first_ff;
         chk_last_in  = (iss_addr_ff == end_addr_ff);
         if (iss_active_ff) begin
            iss_addr_in   = iss_addr_ff + WADDR_W'(1);
            iss_active_in = (iss_addr_ff != end_addr_ff);
            iss_first_in  = 1'b0;
         end
         if (hit) begin
            wr_addr_in  = chk_addr_ff;
            wr_word_in  = ram_rd_data | (WORD_BITS'(1) << free_idx);
            found_id_in = (ID_W'(chk_addr_ff) << BIT_W) | ID_W'(free_idx);
         end else if (miss_last && !pass2_ff) begin
            // wrap: search again from id zero up to the pointer word
            pass2_in      = 1'b1;
            iss_addr_in   = '0;
            end_addr_in   = start_word;
            iss_active_in = 1'b1;
            iss_first_in  = 1'b0;
            chk_valid_in  = 1'b0;
         end
      end

      if (cmd.commit) begin
         ram_wr_en       = 1'b1;
         ram_wr_addr     = wr_addr_ff;
         ram_wr_data     = wr_word_ff;
         used_total_in   = used_total_ff + CNT_W'(1);
         search_start_in = CNT_W'(found_id_ff) + CNT_W'(1);
         rsp_strobe_in   = 1'b1;
         rsp_status_in   = STATUS_OK;
         rsp_id_in       = found_id_ff;
         rsp_in_use_in   = used_total_ff + CNT_W'(1);
      end

      if (cmd.rel_commit) begin
         rsp_strobe_in = 1'b1;
         rsp_id_in     = '0;
         if ((ram_rd_data & rid_mask) != '0) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = rid_word;
            ram_wr_data = ram_rd_data & ~rid_mask;
            if (used_total_ff != '0) begin
               used_total_in = used_total_ff - CNT_W'(1);
            end
            rsp_status_in = STATUS_OK;
            rsp_in_use_in = used_total_in;
         end else begin
            rsp_status_in = STATUS_NOT_USED;
            rsp_in_use_in = used_total_ff;
         end
      end

      if (cmd.resp_err) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = cmd.resp_code;
         rsp_id_in     = '0;
         rsp_in_use_in = used_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_total_ff   <= '0;
         search_start_ff <= '0;
         clr_addr_ff     <= '0;
         iss_active_ff   <= 1'b0;
         iss_first_ff    <= 1'b0;
         pass2_ff        <= 1'b0;
         chk_valid_ff    <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         used_total_ff   <= used_total_in;
         search_start_ff <= search_start_in;
         clr_addr_ff     <= clr_addr_in;
         iss_active_ff   <= iss_active_in;
         iss_first_ff    <= iss_first_in;
         pass2_ff        <= pass2_in;
         chk_valid_ff    <= chk_valid_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      rid_ff        <= rid_in;
      iss_addr_ff   <= iss_addr_in;
      end_addr_ff   <= end_addr_in;
      chk_addr_ff   <= chk_addr_in;
      chk_first_ff  <= chk_first_in;
      chk_last_ff   <= chk_last_in;
      wr_addr_ff    <= wr_addr_in;
      wr_word_ff    <= wr_word_in;
      found_id_ff   <= found_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_in_use_ff <= rsp_in_use_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_granted_id = rsp_id_ff;
   assign rsp_in_use     = rsp_in_use_ff;

endmodule

// ===== rtl/next_fit_bitmap_id_allocator.sv =====
// ----------------------------------------------------------------------------
// next_fit_bitmap_id_allocator: next-fit bitmap id allocator
// Hands out and takes back ids kept as one used bit each in a word-wide
// bitmap ram, searching next-fit from a rotating pointer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every request
// gives exactly one result, shown for one cycle with rsp_strobe high, and
// the receiver cannot stall it. After reset the block runs a clearing pass
// that writes all MAX_IDS/WORD_BITS bitmap words (16 at the default sizes),
// one per cycle, with busy high. An allocate scans the bitmap next-fit
// from the pointer word, wrapping to id zero when no free id lies above
// the pointer; the word scan reads one ram word per cycle, and at most
// 17 words are checked at the default sizes. A release reads the word of
// its id and clears the bit if it is set; a request rejected on range or
// an empty usable range is answered from the decode state. The next request can be
// taken in the cycle its predecessor's result is shown. The user must write
// usable_count over the csr port only while busy is low and no result is
// pending; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module next_fit_bitmap_id_allocator
   import nfbia_pkg::*;
#(
   parameter int MAX_IDS   = DEFAULT_MAX_IDS,
   parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_op,
   input  logic [$clog2(MAX_IDS)-1:0] req_release_id,
   // result channel
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [$clog2(MAX_IDS)-1:0] rsp_granted_id,
   output logic [$clog2(MAX_IDS):0]   rsp_in_use,
   // csr port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int MAP_WORDS = MAX_IDS / WORD_BITS;
   localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CNT_W     = $clog2(MAX_IDS) + 1;

   nfbia_cmd_type  cmd;
   nfbia_stat_type stat;

   // csr register: number of usable ids
   logic [CNT_W-1:0] usable_count_ff, usable_count_in;
   logic             csr_write;
   logic             csr_hit;

   // bitmap ram
   logic                 ram_wr_en;
   logic [WADDR_W-1:0]   ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [WADDR_W-1:0]   ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   // register index sits at byte address bit 2
   assign csr_hit   = (paddr[2:2] == 1'(CSR_USABLE_COUNT));
   assign csr_write = psel && penable && pwrite && csr_hit;
   assign pready    = 1'b1;

   always_comb begin
      usable_count_in = usable_count_ff;
      if (csr_write) begin
         usable_count_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_count_ff <= CNT_W'(DEFAULT_USABLE);
      end else begin
         usable_count_ff <= usable_count_in;
      end
   end

   // reads outside the register list return zero
   assign prdata = csr_hit ? 32'(usable_count_ff) : 32'd0;

   nfbia_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   nfbia_datapath #(
      .MAX_IDS   (MAX_IDS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_op),
      .req_release_id (req_release_id),
      .usable_count   (usable_count_ff),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_granted_id (rsp_granted_id),
      .rsp_in_use     (rsp_in_use)
   );

   // used-id bitmap, one word per row
   nfbia_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== bench/nfbia_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// nfbia_scoreboard_pkg: expected-result tracking for the id allocator bench
// Keeps a private copy of the bitmap, count and next-fit pointer, works out
// the answer of every accepted request and compares the block's answers.
// ----------------------------------------------------------------------------
package nfbia_scoreboard_pkg;

   import nfbia_pkg::*;

   localparam int ID_W      = $clog2(DEFAULT_MAX_IDS);
   localparam int MAP_WORDS = DEFAULT_MAX_IDS / DEFAULT_WORD_BITS;

   typedef struct {
      status_type       status;
      logic [ID_W-1:0]  granted_id;
      logic [ID_W:0]    in_use;
   } id_answer_type;

   class id_alloc_scoreboard;

      bit [DEFAULT_WORD_BITS-1:0] used_words [MAP_WORDS];
      int unsigned                used_total;
      int unsigned                next_ptr;
      bit [ID_W:0]                usable_count;
      id_answer_type              answer_q [$];
      int unsigned                errors;
      int unsigned                checked;
      int unsigned                alloc_count;
      int unsigned                release_count;
      int unsigned                status_seen [4];
      int unsigned                settings;

      function new();
         foreach (used_words[w]) used_words[w] = '0;
         used_total   = 0;
         next_ptr     = 0;
         usable_count = (ID_W + 1)'(DEFAULT_USABLE);
      endfunction

      function bit id_used(int unsigned id);
         return used_words[id / DEFAULT_WORD_BITS][id % DEFAULT_WORD_BITS];
      endfunction

      // first free id in [from, limit), limit if none
      function int unsigned first_free(int unsigned from, int unsigned limit);
         for (int unsigned i = from; i < limit; i++)
            if (!id_used(i)) return i;
         return limit;
      endfunction

      function void write_usable(bit [31:0] value);
         usable_count = value[ID_W:0];
         settings++;
      endfunction

      function void note_request(logic op, logic [ID_W-1:0] rid);
         id_answer_type ans;
         int unsigned   limit;
         int unsigned   id;
         limit = (usable_count > DEFAULT_MAX_IDS) ? DEFAULT_MAX_IDS : usable_count;
         ans.status     = STATUS_OK;
         ans.granted_id = '0;
         if (op == OP_ALLOC) begin
            alloc_count++;
            id = first_free(next_ptr, limit);
            if (id >= limit) id = first_free(0, limit);
            if (id >= limit) begin
               ans.status = STATUS_FULL;
            end else begin
               used_words[id / DEFAULT_WORD_BITS][id % DEFAULT_WORD_BITS] = 1'b1;
               used_total++;
               next_ptr       = id + 1;
               ans.granted_id = ID_W'(id);
            end
         end else begin
            release_count++;
            if (rid >= limit) begin
               ans.status = STATUS_RANGE;
            end else if (!id_used(rid)) begin
               ans.status = STATUS_NOT_USED;
            end else begin
               used_words[rid / DEFAULT_WORD_BITS][rid % DEFAULT_WORD_BITS] = 1'b0;
               if (used_total > 0) used_total--;
            end
         end
         ans.in_use = (ID_W + 1)'(used_total);
         status_seen[ans.status]++;
         answer_q.push_back(ans);
      endfunction

      // random id that is marked used, any id when none is
      function int unsigned pick_used();
         int unsigned ids [$];
         for (int unsigned i = 0; i < DEFAULT_MAX_IDS; i++)
            if (id_used(i)) ids.push_back(i);
         if (ids.size() == 0) return $urandom_range(DEFAULT_MAX_IDS - 1);
         return ids[$urandom_range(ids.size() - 1)];
      endfunction

      function int unsigned pending();
         return answer_q.size();
      endfunction

      task report_mismatch(string what, longint unsigned got, longint unsigned want);
         errors++;
         $display("mismatch: %s got %0d want %0d (after %0d results)",
                  what, got, want, checked);
      endtask

      task check_result(logic [1:0] status, logic [ID_W-1:0] gid, logic [ID_W:0] in_use);
         id_answer_type want;
         if (answer_q.size() == 0) begin
            report_mismatch("result with no request outstanding, status", status, 0);
         end else begin
            want = answer_q.pop_front();
            checked++;
            if (status !== want.status)
               report_mismatch("status", status, want.status);
            if (gid !== want.granted_id)
               report_mismatch("granted_id", gid, want.granted_id);
            if (in_use !== want.in_use)
               report_mismatch("in_use", in_use, want.in_use);
         end
      endtask

   endclass

endpackage

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for the next-fit bitmap id allocator
// Drives allocate and release transactions through the start/busy port,
// reprograms the usable count over the csr port between phases and checks
// every one-cycle result against a scoreboard that tracks the bitmap.
// ----------------------------------------------------------------------------
module tb_top
   import nfbia_pkg::*;
   import nfbia_scoreboard_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // cycles without any transaction before the run is declared hung
   localparam int STALL_LIMIT = 4000;
   // settle time after the last result, a bit over the worst allocate
   localparam int TAIL_CYCLES = 30;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_op;
   logic [ID_W-1:0]   req_release_id;
   logic              rsp_strobe;
   logic [1:0]        rsp_status;
   logic [ID_W-1:0]   rsp_granted_id;
   logic [ID_W:0]     rsp_in_use;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   id_alloc_scoreboard sb;

   next_fit_bitmap_id_allocator u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_release_id (req_release_id),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_granted_id (rsp_granted_id),
      .rsp_in_use     (rsp_in_use),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one request transaction; called at a rising edge, returns at the edge
   // where the block took it (plus any idle gap after it)
   task automatic send_request(logic op, int unsigned rid, int idle_pct);
      int unsigned gap;
      start          <= 1'b1;
      req_op         <= op;
      req_release_id <= ID_W'(rid);
      do @(posedge clock); while (busy);
      // prediction happens in this process so the next pick sees it
      sb.note_request(op, ID_W'(rid));
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 100) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop start and let every outstanding result come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0 || busy);
   endtask

   // write the usable count, then read it straight back in the next transfer
   task automatic program_usable(bit [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(CSR_USABLE_COUNT * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_usable(value);
      // read setup follows the write access directly, psel stays high
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {21'd0, value[ID_W:0]})
         sb.report_mismatch("usable_count read back", prdata, value[ID_W:0]);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // random traffic: allocate share and idle share set per phase; most
   // releases target an id that is actually in use, the rest are noise
   task automatic run_traffic(int count, int idle_pct, int alloc_pct);
      int unsigned rid;
      logic        op;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_RELEASE;
         if (op == OP_ALLOC)
            rid = $urandom_range(DEFAULT_MAX_IDS - 1);
         else if ($urandom_range(99) < 70)
            rid = sb.pick_used();
         else
            rid = $urandom_range(DEFAULT_MAX_IDS - 1);
         send_request(op, rid, idle_pct);
      end
   endtask

   // result side: the receiver cannot stall, every strobe is a transaction
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_status, rsp_granted_id, rsp_in_use);
   end

   // watchdog on cycles with no transaction on any port
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe || psel) quiet = 0;
         else quiet++;
      end
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      sb             = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_op         = OP_ALLOC;
      req_release_id = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset usable count; first request also waits
      // out the clearing pass
      send_request(OP_ALLOC, 1023, 0);
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_RELEASE, 0, 0);
      send_request(OP_RELEASE, 0, 0);      // already free
      send_request(OP_RELEASE, 1023, 0);   // past the usable count
      send_request(OP_RELEASE, 999, 3);    // top usable id, never granted
      drain();

      // single usable id: pointer sits past the end, search wraps to zero,
      // then the block is full; id 1 is stranded above the count
      program_usable(1);
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_RELEASE, 1, 0);
      send_request(OP_RELEASE, 0, 0);
      drain();

      // nothing usable at all
      program_usable(0);
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_RELEASE, 0, 0);
      drain();

      // count above capacity acts as full capacity; stranded id comes back
      program_usable(2047);
      send_request(OP_RELEASE, 1, 0);
      send_request(OP_RELEASE, 1023, 0);
      send_request(OP_ALLOC, 1023, 0);
      send_request(OP_ALLOC, 512, 0);
      drain();

      // random phases over several usable counts and idle patterns
      program_usable(70);
      run_traffic(140, 0, 65);
      drain();
      program_usable(5);
      run_traffic(90, 79, 55);
      drain();
      program_usable(1024);
      run_traffic(120, 6, 70);
      drain();
      program_usable(130);
      run_traffic(110, 79, 60);
      drain();
      program_usable(64);
      run_traffic(100, 6, 60);
      drain();
      program_usable(0);
      run_traffic(15, 0, 50);
      drain();
      program_usable(3);
      run_traffic(40, 6, 50);
      drain();
      program_usable(2047);
      run_traffic(60, 79, 50);
      drain();
      program_usable(1000);
      run_traffic(60, 0, 50);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch("requests left without a result", sb.pending(), 0);

      $display("covered %0d requests (%0d allocate, %0d release) over %0d usable-count settings",
               sb.alloc_count + sb.release_count, sb.alloc_count, sb.release_count,
               sb.settings);
      $display("answers checked %0d: ok %0d, full %0d, out of range %0d, not allocated %0d",
               sb.checked, sb.status_seen[STATUS_OK], sb.status_seen[STATUS_FULL],
               sb.status_seen[STATUS_RANGE], sb.status_seen[STATUS_NOT_USED]);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
